// File: src/mns_pkg.sv
// mns_pkg: types and constants shared by the moore neighborhood stats block
// holds the word structs, the per-lane result struct and sizes
// no dependencies
package mns_pkg;

  localparam int unsigned ValueWidth = 8;
  localparam int unsigned NbrCount   = 8;
  localparam int unsigned CountWidth = $clog2(NbrCount + 1);
  localparam logic [NbrCount-1:0] SelectMaskReset = '1;

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [NbrCount-1:0]   nbr_mask_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    value_t    value_0;
    value_t    value_1;
    value_t    value_2;
    value_t    value_3;
    value_t    value_4;
    value_t    value_5;
    value_t    value_6;
    value_t    value_7;
    nbr_mask_t in_domain;
    value_t    query_value;
    nbr_mask_t query_mask;
  } in_word_t;

  typedef struct packed {
    value_t    max_value;
    value_t    min_value;
    logic      no_valid;
    count_t    equal_count;
    count_t    undefined_count;
    logic      all_defined;
    logic      masked_all_equal;
    nbr_mask_t first_match_res;
  } out_word_t;

  typedef struct packed {
    logic   valid;
    logic   eq;
    logic   mismatch;
    logic   undef;
    value_t max_cand;
    value_t min_cand;
  } lane_res_t;

endpackage

// File: src/mns_lane.sv
// mns_lane: per-neighbor evaluation, one copy for each of the eight neighbors
// depends on mns_pkg
module mns_lane (
  input  mns_pkg::value_t    value,
  input  logic               dom,
  input  logic               sel,
  input  logic               qmask,
  input  mns_pkg::value_t    query_value,
  output mns_pkg::lane_res_t res
);
  import mns_pkg::*;

  logic valid;
  logic match;

  assign valid = sel & dom;
  assign match = (value == query_value);

  always_comb begin
    res.valid    = valid;
    res.eq       = valid & match;
    res.mismatch = valid & ~match & qmask;
    res.undef    = sel & ~dom;
    res.max_cand = valid ? value : '0;
    res.min_cand = valid ? value : '1;
  end

endmodule

// File: src/mns_merge.sv
// mns_merge: combines the eight lane results into one output word
// depends on mns_pkg
module mns_merge (
  input  mns_pkg::lane_res_t lanes [mns_pkg::NbrCount],
  output mns_pkg::out_word_t res
);
  import mns_pkg::*;

  nbr_mask_t valid_vec;
  nbr_mask_t eq_vec;
  nbr_mask_t mis_vec;
  nbr_mask_t undef_vec;
  value_t    vmax;
  value_t    vmin;

  always_comb begin
    vmax = '0;
    vmin = '1;
    for (int k = 0; k < NbrCount; k++) begin
      valid_vec[k] = lanes[k].valid;
      eq_vec[k]    = lanes[k].eq;
      mis_vec[k]   = lanes[k].mismatch;
      undef_vec[k] = lanes[k].undef;
      if (lanes[k].max_cand > vmax) begin
        vmax = lanes[k].max_cand;
      end
      if (lanes[k].min_cand < vmin) begin
        vmin = lanes[k].min_cand;
      end
    end
  end

  always_comb begin
    res.no_valid         = ~|valid_vec;
    res.max_value        = res.no_valid ? '0 : vmax;
    res.min_value        = res.no_valid ? '0 : vmin;
    res.equal_count      = count_t'($countones(eq_vec));
    res.undefined_count  = count_t'($countones(undef_vec));
    res.all_defined      = ~|undef_vec;
    res.masked_all_equal = ~|mis_vec;
    res.first_match_res  = eq_vec & (~eq_vec + nbr_mask_t'(1));
  end

endmodule

// File: src/moore_neighborhood_stats.sv
// moore_neighborhood_stats: min, max, counts and match flags over the eight
// neighbors of a 3x3 window; top level, depends on mns_pkg, mns_lane, mns_merge
//
// Takes one window word per cycle and returns one result word for each, in
// order. Eight lanes evaluate the neighbors in parallel into a lane register,
// a merge stage reduces them into the output register that drives out_data;
// throughput is one word per cycle, limited only by out_ready. The select mask
// resets to all ones and is written through the cfg port, which is always
// ready; write it only while the block is idle.
module moore_neighborhood_stats (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mns_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mns_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  mns_pkg::nbr_mask_t cfg_data
);
  import mns_pkg::*;

  nbr_mask_t select_mask_r;
  value_t    values [NbrCount];
  lane_res_t lane_res [NbrCount];
  lane_res_t lane_r [NbrCount];
  logic      s1_valid_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t merge_res;
  logic      s2_adv;
  logic      s1_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      select_mask_r <= SelectMaskReset;
    end else if (cfg_valid && cfg_ready) begin
      select_mask_r <= cfg_data;
    end
  end

  assign values[0] = in_data.value_0;
  assign values[1] = in_data.value_1;
  assign values[2] = in_data.value_2;
  assign values[3] = in_data.value_3;
  assign values[4] = in_data.value_4;
  assign values[5] = in_data.value_5;
  assign values[6] = in_data.value_6;
  assign values[7] = in_data.value_7;

  for (genvar k = 0; k < NbrCount; k++) begin : g_lane
    mns_lane u_lane (
      .value       (values[k]),
      .dom         (in_data.in_domain[k]),
      .sel         (select_mask_r[k]),
      .qmask       (in_data.query_mask[k]),
      .query_value (in_data.query_value),
      .res         (lane_res[k])
    );
  end

  // stall control
  assign s2_adv   = ~out_valid_r | out_ready;
  assign s1_adv   = ~s1_valid_r | s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      lane_r <= lane_res;
    end
  end

  mns_merge u_merge (
    .lanes (lane_r),
    .res   (merge_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      out_data_r <= merge_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/mns_checker.sv
// mns_checker: port-level checks on the moore neighborhood stats block
// depends on mns_pkg; bound to moore_neighborhood_stats below
module mns_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mns_pkg::out_word_t out_data
);
  import mns_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_valid |->
      out_data.max_value == '0 && out_data.min_value == '0 &&
      out_data.equal_count == '0 && out_data.first_match_res == '0)
    else $error("no valid neighbor but nonzero statistics");

  a_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.all_defined == (out_data.undefined_count == '0))
    else $error("all_defined disagrees with undefined_count");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_data.first_match_res) &&
      ((out_data.first_match_res != '0) == (out_data.equal_count != '0)) &&
      (out_data.no_valid || out_data.min_value <= out_data.max_value))
    else $error("inconsistent match or range fields");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind moore_neighborhood_stats mns_checker u_mns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/tb.sv
// tb: self-checking testbench for moore_neighborhood_stats
// predicts every result word from its own neighborhood model and checks it
// depends on mns_pkg and the moore_neighborhood_stats top level
`timescale 1ns / 1ps

module tb;
  import mns_pkg::*;

  localparam int unsigned StallLimit = 3000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  nbr_mask_t cfg_data;

  out_word_t   expected_words[$];
  nbr_mask_t   model_mask = SelectMaskReset;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  moore_neighborhood_stats dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic in_word_t pack_window(input value_t v [8], input nbr_mask_t dom,
                                           input value_t q, input nbr_mask_t qm);
    in_word_t w;
    w.value_0     = v[0];
    w.value_1     = v[1];
    w.value_2     = v[2];
    w.value_3     = v[3];
    w.value_4     = v[4];
    w.value_5     = v[5];
    w.value_6     = v[6];
    w.value_7     = v[7];
    w.in_domain   = dom;
    w.query_value = q;
    w.query_mask  = qm;
    return w;
  endfunction

  function automatic out_word_t predict_stats(input in_word_t w, input nbr_mask_t sel);
    out_word_t   r;
    value_t      v [8];
    nbr_mask_t   live;
    bit          seen;
    int unsigned undef;
    v = '{w.value_0, w.value_1, w.value_2, w.value_3,
          w.value_4, w.value_5, w.value_6, w.value_7};
    live = sel & w.in_domain;
    r = '0;
    r.masked_all_equal = 1'b1;
    seen = 1'b0;
    undef = 0;
    for (int k = 0; k < NbrCount; k++) begin
      if (live[k]) begin
        if (!seen || v[k] > r.max_value) r.max_value = v[k];
        if (!seen || v[k] < r.min_value) r.min_value = v[k];
        seen = 1'b1;
        if (v[k] == w.query_value) begin
          r.equal_count = r.equal_count + 1'b1;
          if (r.first_match_res == '0) r.first_match_res[k] = 1'b1;
        end else if (w.query_mask[k]) begin
          r.masked_all_equal = 1'b0;
        end
      end
      if (sel[k] && !w.in_domain[k]) undef++;
    end
    r.no_valid        = !seen;
    r.undefined_count = count_t'(undef);
    r.all_defined     = (undef == 0);
    return r;
  endfunction

  function automatic in_word_t random_window();
    value_t    v [8];
    value_t    q;
    nbr_mask_t dom;
    nbr_mask_t qm;
    int        mode;
    mode = $urandom_range(0, 3);
    q = value_t'($urandom);
    if (mode == 3) q = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    for (int k = 0; k < NbrCount; k++) begin
      case (mode)
        0: v[k] = value_t'($urandom);
        1: begin
          case ($urandom_range(0, 3))
            0: v[k] = q;
            1: v[k] = q ^ 8'h01;
            2: v[k] = value_t'(q + 1);
            default: v[k] = value_t'($urandom);
          endcase
        end
        2: v[k] = ($urandom_range(0, 7) == 0) ? value_t'($urandom) : q;
        default: v[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
    end
    dom = ($urandom_range(0, 3) == 0) ? nbr_mask_t'('1) : nbr_mask_t'($urandom);
    qm = (mode == 2 && $urandom_range(0, 1)) ? nbr_mask_t'('1) : nbr_mask_t'($urandom);
    return pack_window(v, dom, q, qm);
  endfunction

  task automatic report_field(input string fld, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, fld, exp_v, act_v);
    fail_count++;
  endtask

  task automatic check_word(input out_word_t act);
    out_word_t exp_w;
    if (expected_words.size() == 0) begin
      $display("%0t: result word %h with nothing expected", $time, act);
      fail_count++;
    end else begin
      exp_w = expected_words.pop_front();
      if (act.max_value !== exp_w.max_value)
        report_field("max_value", exp_w.max_value, act.max_value);
      if (act.min_value !== exp_w.min_value)
        report_field("min_value", exp_w.min_value, act.min_value);
      if (act.no_valid !== exp_w.no_valid)
        report_field("no_valid", 8'(exp_w.no_valid), 8'(act.no_valid));
      if (act.equal_count !== exp_w.equal_count)
        report_field("equal_count", 8'(exp_w.equal_count), 8'(act.equal_count));
      if (act.undefined_count !== exp_w.undefined_count)
        report_field("undefined_count", 8'(exp_w.undefined_count),
                     8'(act.undefined_count));
      if (act.all_defined !== exp_w.all_defined)
        report_field("all_defined", 8'(exp_w.all_defined), 8'(act.all_defined));
      if (act.masked_all_equal !== exp_w.masked_all_equal)
        report_field("masked_all_equal", 8'(exp_w.masked_all_equal),
                     8'(act.masked_all_equal));
      if (act.first_match_res !== exp_w.first_match_res)
        report_field("first_match_res", exp_w.first_match_res, act.first_match_res);
    end
  endtask

  // handshake monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_words.push_back(predict_stats(in_data, model_mask));
      if (out_valid && out_ready) check_word(out_data);
      if (cfg_valid && cfg_ready) model_mask = cfg_data;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_window(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_mask(input nbr_mask_t m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_windows();
    value_t v [8];
    for (int k = 0; k < 8; k++) v[k] = 8'h00;
    send_window(pack_window(v, 8'hFF, 8'h00, 8'hFF));
    send_window(pack_window(v, 8'hFF, 8'h01, 8'h00));
    send_window(pack_window(v, 8'hFF, 8'h01, 8'hFF));
    for (int k = 0; k < 8; k++) v[k] = 8'hFF;
    send_window(pack_window(v, 8'hFF, 8'hFF, 8'h00));
    // nothing in the domain
    send_window(pack_window(v, 8'h00, 8'hFF, 8'hFF));
    for (int k = 0; k < 8; k++) v[k] = value_t'(k * 36);
    send_window(pack_window(v, 8'hFF, v[3], 8'h08));
    for (int k = 0; k < 8; k++) v[k] = value_t'(255 - k * 36);
    send_window(pack_window(v, 8'hFF, v[7], 8'hF0));
    for (int k = 0; k < 8; k++) v[k] = 8'h80;
    v[0] = 8'h00;
    v[7] = 8'hFF;
    send_window(pack_window(v, 8'hFF, 8'hFF, 8'h80));
    // out-of-domain extremes and mismatches must be ignored
    v[2] = 8'hFF;
    v[5] = 8'h00;
    v[0] = 8'h40;
    v[7] = 8'h40;
    send_window(pack_window(v, 8'hDB, 8'h80, 8'h24));
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 8; j++) v[j] = value_t'($urandom);
      send_window(pack_window(v, nbr_mask_t'(1 << k), v[k], 8'hFF));
    end
  endtask

  task automatic test_select_mask_extremes();
    value_t v [8];
    // empty selection
    write_mask(8'h00);
    for (int k = 0; k < 8; k++) v[k] = value_t'($urandom);
    send_window(pack_window(v, 8'hFF, v[0], 8'hFF));
    send_window(pack_window(v, 8'h00, v[1], 8'h00));
    write_mask(8'h81);
    send_window(pack_window(v, 8'h7E, v[0], 8'hFF));
    send_window(pack_window(v, 8'h80, v[7], 8'h01));
    write_mask(8'h7E);
    send_window(pack_window(v, 8'hFF, v[4], 8'h3C));
    send_window(pack_window(v, 8'h81, v[4], 8'hFF));
    write_mask(8'hFF);
  endtask

  task automatic test_random_phase(input int unsigned n, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    nbr_mask_t m;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 140 == 0) begin
        case ($urandom_range(0, 5))
          0: m = 8'h00;
          1: m = 8'hFF;
          default: m = nbr_mask_t'($urandom);
        endcase
        write_mask(m);
      end
      send_window(random_window());
    end
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 69;
    for (int i = 0; i < 30; i++) send_window(random_window());
    wait_drained();
    for (int i = 0; i < 30; i++) send_window(random_window());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_windows();
    test_select_mask_extremes();
    test_random_phase(420, 0, 0);
    test_random_phase(420, 69, 0);
    test_random_phase(420, 0, 69);
    test_random_phase(420, 27, 27);
    test_drain_pause();
    wait_drained();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mns_pkg.sv
src/mns_lane.sv
src/mns_merge.sv
src/moore_neighborhood_stats.sv
src/mns_checker.sv
tb/tb.sv
